@@ hw/rtl/bpmd_pkg.sv @@
// Shared types, constants and helpers for the block median DPCM predictor.
// Used by bpmd_dpcm and block_pixel_median_dpcm_top; no dependencies.
package bpmd_pkg;

   localparam int DATA_W     = 12;
   localparam int RES_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int BPR_W      = 9;
   localparam int BSIZE_W    = 5;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [RES_W-1:0]  result_type;

   localparam sample_type DC_START = 12'sh080;
   localparam sample_type SAT_HI   = 12'sh7FF;
   localparam sample_type SAT_LO   = 12'sh800;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BSIZE = 2'd2;

   localparam logic MODE_DPCM = 1'b0;
   localparam logic MODE_PASS = 1'b1;
   localparam logic FUNC_FWD  = 1'b0;
   localparam logic FUNC_INV  = 1'b1;

   localparam logic               MODE_RST  = MODE_DPCM;
   localparam logic [BPR_W-1:0]   BPR_RST   = 9'd64;
   localparam logic [BSIZE_W-1:0] BSIZE_RST = 5'd8;

   // position flags of one item, carried from the front end to the datapath
   typedef struct packed {
      logic inverse;
      logic first_blk;
      logic first_row;
      logic top_row;
      logic col_zero;
      logic last_col;
      logic bcol_zero;
      logic bcol_last;
      logic done;
   } ctl_type;

   function automatic sample_type median3(input sample_type a, input sample_type b,
                                          input sample_type c);
      sample_type lo;
      sample_type hi;
      sample_type m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) m = lo;
      else if (c >= hi) m = hi;
      else m = c;
      return m;
   endfunction

endpackage

@@ hw/rtl/block_pixel_median_dpcm_top.sv @@
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless rsp_stall holds a result; the input
// and result registers decouple both sides; block/edge reads happen on accept.
// Reset: synchronous; clears position, pipeline valids and configuration to
// defaults. Block and edge memories keep their contents until written.
// Depends on bpmd_pkg and bpmd_dpcm.
module block_pixel_median_dpcm_top #(
   parameter int MAX_BLOCK_SIZE     = 16,
   parameter int MAX_BLOCKS_PER_ROW = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bpmd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bpmd_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  bpmd_pkg::sample_type                   req_sample_value,
   input  logic                                   req_frame_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bpmd_pkg::result_type                   rsp_result_value,
   output logic                                   rsp_block_done
);
   import bpmd_pkg::*;

   localparam int CW  = $clog2(MAX_BLOCK_SIZE);
   localparam int BCW = $clog2(MAX_BLOCKS_PER_ROW);
   localparam logic [CW-1:0]  NM1_MAX   = CW'(MAX_BLOCK_SIZE - 1);
   localparam logic [BCW-1:0] BPRM1_MAX = BCW'(MAX_BLOCKS_PER_ROW - 1);

   typedef sample_type [MAX_BLOCK_SIZE-1:0] word_type;

   // configuration
   logic               mode_ff;
   logic [BPR_W-1:0]   bpr_ff;
   logic [BSIZE_W-1:0] bsize_ff;
   logic [CW-1:0]      nm1;
   logic [BCW-1:0]     bprm1;

   // position
   logic [CW-1:0]  col_ff, col_in, col_e;
   logic [CW-1:0]  row_ff, row_in, row_e;
   logic [BCW-1:0] bcol_ff, bcol_in, bcol_e;
   logic           first_blk_ff, first_blk_in, first_blk_e;
   logic           first_row_ff, first_row_in, first_row_e;
   logic           last_col, last_row, last_bcol, pos_done;
   logic [CW-1:0]  uprow_e;
   logic [BCW-1:0] lb_e, b1_e;
   ctl_type        ctl_e;

   // handshake
   logic req_acc, s1_go, s1_fire, edge_we;

   // input stage
   logic           s1_vld_ff;
   ctl_type        s1_ctl_ff;
   logic [CW-1:0]  s1_col_ff, s1_row_ff, s1_uprow_ff;
   logic [BCW-1:0] s1_bcol_ff, s1_lb_ff, s1_b1_ff;
   sample_type     s1_x_ff;
   result_type     s1_result;
   sample_type     s1_store;

   // memories and their read registers
   word_type row_mem [MAX_BLOCK_SIZE];
   word_type col_mem [MAX_BLOCK_SIZE];
   word_type rgt_mem [MAX_BLOCKS_PER_ROW];
   word_type bot_mem [MAX_BLOCKS_PER_ROW];
   word_type rd_cur_ff, rd_up_ff, rd_col_ff, rd_rgt_ff, rd_bot0_ff, rd_bot1_ff;
   word_type cur_w, up_w, col_w, rgt_w, bot0_w, bot1_w;
   word_type rgt_new, bot_new;

   // write bypass for reads taken at the same edge as a write
   logic           byp_vld_ff, byp_edge_ff;
   logic [CW-1:0]  byp_row_ff, byp_col_ff;
   sample_type     byp_val_ff;
   logic [BCW-1:0] byp_bcol_ff;
   word_type       byp_rgt_ff, byp_bot_ff;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_result_ff;
   logic       rsp_done_ff;

   // clamp the size registers
   always_comb begin
      if (bsize_ff < BSIZE_W'(2)) nm1 = CW'(1);
      else if (int'(bsize_ff) > MAX_BLOCK_SIZE) nm1 = NM1_MAX;
      else nm1 = CW'(bsize_ff - 1'b1);
      if (bpr_ff < BPR_W'(2)) bprm1 = BCW'(1);
      else if (int'(bpr_ff) > MAX_BLOCKS_PER_ROW) bprm1 = BPRM1_MAX;
      else bprm1 = BCW'(bpr_ff - 1'b1);
   end

   assign s1_go     = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_vld_ff && s1_go;
   assign req_stall = s1_vld_ff && !s1_go;
   assign req_acc   = req_valid && !req_stall;
   assign edge_we   = s1_fire && s1_ctl_ff.done && (s1_ctl_ff.inverse == FUNC_INV)
                      && (mode_ff == MODE_DPCM);

   // position of the incoming item and the next position
   always_comb begin
      col_e       = req_frame_start ? '0 : col_ff;
      row_e       = req_frame_start ? '0 : row_ff;
      bcol_e      = req_frame_start ? '0 : bcol_ff;
      first_blk_e = req_frame_start ? 1'b1 : first_blk_ff;
      first_row_e = req_frame_start ? 1'b1 : first_row_ff;
      // saturate a position left beyond a shrunken size
      if (col_e > nm1) col_e = nm1;
      if (row_e > nm1) row_e = nm1;
      if (bcol_e > bprm1) bcol_e = bprm1;
      last_col  = (col_e == nm1);
      last_row  = (row_e == nm1);
      last_bcol = (bcol_e == bprm1);
      pos_done  = last_col && last_row;

      col_in       = col_e + 1'b1;
      row_in       = row_e;
      bcol_in      = bcol_e;
      first_blk_in = first_blk_e;
      first_row_in = first_row_e;
      if (last_col) begin
         col_in = '0;
         row_in = row_e + 1'b1;
         if (last_row) begin
            row_in       = '0;
            first_blk_in = 1'b0;
            if (last_bcol) begin
               bcol_in      = '0;
               first_row_in = 1'b0;
            end else begin
               bcol_in = bcol_e + 1'b1;
            end
         end
      end

      uprow_e = (row_e == '0) ? '0 : row_e - 1'b1;
      lb_e    = (bcol_e == '0) ? bprm1 : bcol_e - 1'b1;
      b1_e    = last_bcol ? bcol_e : bcol_e + 1'b1;

      ctl_e.inverse   = req_func;
      ctl_e.first_blk = first_blk_e;
      ctl_e.first_row = first_row_e;
      ctl_e.top_row   = (row_e == '0);
      ctl_e.col_zero  = (col_e == '0);
      ctl_e.last_col  = last_col;
      ctl_e.bcol_zero = (bcol_e == '0);
      ctl_e.bcol_last = last_bcol;
      ctl_e.done      = pos_done;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RST;
         bpr_ff       <= BPR_RST;
         bsize_ff     <= BSIZE_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         bcol_ff      <= '0;
         first_blk_ff <= 1'b1;
         first_row_ff <= 1'b1;
         s1_vld_ff    <= 1'b0;
         byp_vld_ff   <= 1'b0;
         byp_edge_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:  mode_ff  <= csr_wdata[0];
               CSR_BPR:   bpr_ff   <= csr_wdata[BPR_W-1:0];
               CSR_BSIZE: bsize_ff <= csr_wdata[BSIZE_W-1:0];
               default:   ;
            endcase
         end
         if (req_acc) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            bcol_ff      <= bcol_in;
            first_blk_ff <= first_blk_in;
            first_row_ff <= first_row_in;
            byp_vld_ff   <= s1_fire;
            byp_edge_ff  <= edge_we;
         end
         if (req_acc) s1_vld_ff <= 1'b1;
         else if (s1_fire) s1_vld_ff <= 1'b0;
         if (s1_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ctl_ff   <= ctl_e;
         s1_col_ff   <= col_e;
         s1_row_ff   <= row_e;
         s1_uprow_ff <= uprow_e;
         s1_bcol_ff  <= bcol_e;
         s1_lb_ff    <= lb_e;
         s1_b1_ff    <= b1_e;
         s1_x_ff     <= req_sample_value;
         byp_row_ff  <= s1_row_ff;
         byp_col_ff  <= s1_col_ff;
         byp_val_ff  <= s1_store;
         byp_bcol_ff <= s1_bcol_ff;
         byp_rgt_ff  <= rgt_new;
         byp_bot_ff  <= bot_new;
      end
      if (s1_fire) begin
         rsp_result_ff <= s1_result;
         rsp_done_ff   <= s1_ctl_ff.done;
      end
   end

   // memories: prefetch on accept, write when the item leaves the input stage
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_cur_ff  <= row_mem[row_e];
         rd_up_ff   <= row_mem[uprow_e];
         rd_col_ff  <= col_mem[nm1];
         rd_rgt_ff  <= rgt_mem[lb_e];
         rd_bot0_ff <= bot_mem[bcol_e];
         rd_bot1_ff <= bot_mem[b1_e];
      end
      if (s1_fire) begin
         row_mem[s1_row_ff][s1_col_ff] <= s1_store;
         col_mem[s1_col_ff][s1_row_ff] <= s1_store;
      end
      if (edge_we) begin
         for (int i = 0; i < MAX_BLOCK_SIZE; i++) begin
            if (CW'(i) <= nm1) begin
               rgt_mem[s1_bcol_ff][i] <= rgt_new[i];
               bot_mem[s1_bcol_ff][i] <= bot_new[i];
            end
         end
      end
   end

   // merge the write made at the prefetch edge into the read data
   always_comb begin
      cur_w  = rd_cur_ff;
      up_w   = rd_up_ff;
      col_w  = rd_col_ff;
      rgt_w  = rd_rgt_ff;
      bot0_w = rd_bot0_ff;
      bot1_w = rd_bot1_ff;
      if (byp_vld_ff && byp_row_ff == s1_row_ff) cur_w[byp_col_ff] = byp_val_ff;
      if (byp_vld_ff && byp_row_ff == s1_uprow_ff) up_w[byp_col_ff] = byp_val_ff;
      if (byp_vld_ff && byp_col_ff == nm1) col_w[byp_row_ff] = byp_val_ff;
      for (int i = 0; i < MAX_BLOCK_SIZE; i++) begin
         if (byp_edge_ff && CW'(i) <= nm1) begin
            if (byp_bcol_ff == s1_lb_ff) rgt_w[i] = byp_rgt_ff[i];
            if (byp_bcol_ff == s1_bcol_ff) bot0_w[i] = byp_bot_ff[i];
            if (byp_bcol_ff == s1_b1_ff) bot1_w[i] = byp_bot_ff[i];
         end
      end
      // block edges including the sample being stored now
      rgt_new = col_w;
      rgt_new[s1_row_ff] = s1_store;
      bot_new = cur_w;
      bot_new[s1_col_ff] = s1_store;
   end

   bpmd_dpcm #(
      .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
   ) u_dpcm (
      .ctl      (s1_ctl_ff),
      .mode     (mode_ff),
      .col      (s1_col_ff),
      .row      (s1_row_ff),
      .x        (s1_x_ff),
      .cur_row  (cur_w),
      .up_row   (up_w),
      .rgt_col  (rgt_w),
      .bot_here (bot0_w),
      .bot_next (bot1_w),
      .result   (s1_result),
      .store    (s1_store)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_block_done   = rsp_done_ff;

   a_frame_start : assert property (@(posedge clock) disable iff (reset)
      req_acc && req_frame_start |=> col_ff == CW'(1) && row_ff == '0 && bcol_ff == '0
                                     && first_blk_ff && first_row_ff)
      else $error("position not restarted by frame start");

   a_result_load : assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("item left input stage without a result");

   a_first_block : assert property (@(posedge clock) disable iff (reset)
      $fell(first_blk_ff) |-> $past(req_acc && pos_done))
      else $error("first block flag cleared away from block end");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

endmodule

@@ hw/rtl/bpmd_dpcm.sv @@
// Neighbor selection, median prediction and residual/reconstruction math.
// Purely combinational; depends on bpmd_pkg.
module bpmd_dpcm #(
   parameter int MAX_BLOCK_SIZE = 16
) (
   input  bpmd_pkg::ctl_type                              ctl,
   input  logic                                           mode,
   input  logic [$clog2(MAX_BLOCK_SIZE)-1:0]              col,
   input  logic [$clog2(MAX_BLOCK_SIZE)-1:0]              row,
   input  bpmd_pkg::sample_type                           x,
   input  bpmd_pkg::sample_type [MAX_BLOCK_SIZE-1:0]      cur_row,
   input  bpmd_pkg::sample_type [MAX_BLOCK_SIZE-1:0]      up_row,
   input  bpmd_pkg::sample_type [MAX_BLOCK_SIZE-1:0]      rgt_col,
   input  bpmd_pkg::sample_type [MAX_BLOCK_SIZE-1:0]      bot_here,
   input  bpmd_pkg::sample_type [MAX_BLOCK_SIZE-1:0]      bot_next,
   output bpmd_pkg::result_type                           result,
   output bpmd_pkg::sample_type                           store
);
   import bpmd_pkg::*;

   localparam int CW = $clog2(MAX_BLOCK_SIZE);

   logic [CW-1:0] cm1;
   logic [CW-1:0] cp1;
   sample_type    left;
   sample_type    up;
   sample_type    ur;
   sample_type    pred;
   sample_type    sat;
   result_type    sum;
   result_type    diff;

   always_comb begin
      cm1  = ctl.col_zero ? col : col - 1'b1;
      cp1  = ctl.last_col ? col : col + 1'b1;
      left = cur_row[cm1];
      up   = up_row[col];
      // last column: upper-left stands in for upper-right
      ur   = ctl.last_col ? up_row[cm1] : up_row[cp1];
      if (ctl.first_blk || ctl.first_row) begin
         if (ctl.col_zero) left = ctl.first_blk ? up_row[0] : rgt_col[row];
      end else if (ctl.top_row) begin
         up = bot_here[col];
         if (ctl.col_zero) left = ctl.bcol_zero ? bot_here[col] : rgt_col[0];
         if (ctl.last_col) begin
            ur = (ctl.bcol_last && !ctl.bcol_zero) ? bot_here[cm1] : bot_next[0];
         end else begin
            ur = bot_here[cp1];
         end
      end else begin
         if (ctl.col_zero) left = ctl.bcol_zero ? up_row[0] : rgt_col[row];
      end
      pred = median3(left, up, ur);
      // top row with no block above: left neighbor only
      if ((ctl.first_blk || ctl.first_row) && ctl.top_row) begin
         if (!ctl.col_zero) pred = cur_row[cm1];
         else pred = ctl.first_blk ? DC_START : rgt_col[0];
      end
   end

   always_comb begin
      sum  = result_type'(x) + result_type'(pred);
      diff = result_type'(x) - result_type'(pred);
      if (sum > result_type'(SAT_HI)) sat = SAT_HI;
      else if (sum < result_type'(SAT_LO)) sat = SAT_LO;
      else sat = sum[DATA_W-1:0];
      if (mode == MODE_PASS) begin
         result = result_type'(x);
         store  = x;
      end else if (ctl.inverse == FUNC_INV) begin
         result = result_type'(sat);
         store  = sat;
      end else begin
         result = diff;
         store  = x;
      end
   end

endmodule

@@ sim/bpmd_checker.sv @@
// Result checker for block_pixel_median_dpcm_top: mirrors the register port, predicts
// every result from the accepted items and compares results in order.
// Depends on bpmd_pkg.
module bpmd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bpmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpmd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_func,
   input  bpmd_pkg::sample_type            req_sample_value,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  bpmd_pkg::result_type            rsp_result_value,
   input  logic                            rsp_block_done,
   output int                              fail_count,
   output int                              pending,
   output int                              checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpmd_pkg::*;

   localparam int MAX_N     = 16;
   localparam int MAX_BPR   = 256;
   localparam int EDGE_SPAN = 2 * MAX_N;

   typedef struct packed {
      result_type value;
      logic       done;
   } pixel_result_type;

   pixel_result_type   expected_pixels[$];
   sample_type         tile_mem[MAX_N*MAX_N];
   sample_type         edge_mem[MAX_BPR*EDGE_SPAN];
   int                 col_pos;
   int                 row_pos;
   int                 bcol_pos;
   bit                 top_band;
   bit                 first_tile;
   logic               mode_reg;
   logic [BPR_W-1:0]   bpr_reg;
   logic [BSIZE_W-1:0] bsize_reg;
   int                 mismatches;
   int                 compared;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int tile_at(int r, int c);
      return int'(tile_mem[(r % MAX_N) * MAX_N + (c % MAX_N)]);
   endfunction

   function automatic int right_edge(int bc, int i);
      return int'(edge_mem[(bc % MAX_BPR) * EDGE_SPAN + (i % MAX_N)]);
   endfunction

   function automatic int bottom_edge(int bc, int i);
      return int'(edge_mem[(bc % MAX_BPR) * EDGE_SPAN + MAX_N + (i % MAX_N)]);
   endfunction

   function automatic int median_of_three(int a, int b, int c);
      int lo;
      int hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) return lo;
      if (c >= hi) return hi;
      return c;
   endfunction

   function automatic int neighbor_prediction(int n, int bpr);
      int  left;
      int  up;
      int  ur;
      int  lb;
      bit  lastc;
      lb    = (bcol_pos != 0) ? bcol_pos - 1 : bpr - 1;
      lastc = (col_pos == n - 1);
      if (first_tile || top_band) begin
         if (row_pos == 0) begin
            if (col_pos != 0) return tile_at(0, col_pos - 1);
            return first_tile ? int'(DC_START) : right_edge(lb, 0);
         end
         if (col_pos != 0) left = tile_at(row_pos, col_pos - 1);
         else left = first_tile ? tile_at(row_pos - 1, 0) : right_edge(lb, row_pos);
      end else if (row_pos == 0) begin
         // top row of an inner block: upper neighbours come from the block above
         up = bottom_edge(bcol_pos, col_pos);
         if (bcol_pos == 0) begin
            left = (col_pos != 0) ? tile_at(0, col_pos - 1) : up;
            ur   = lastc ? bottom_edge(1, 0) : bottom_edge(0, col_pos + 1);
         end else begin
            left = (col_pos != 0) ? tile_at(0, col_pos - 1) : right_edge(lb, 0);
            if (bcol_pos == bpr - 1)
               ur = lastc ? bottom_edge(bcol_pos, col_pos - 1)
                          : bottom_edge(bcol_pos, col_pos + 1);
            else
               ur = lastc ? bottom_edge(bcol_pos + 1, 0) : bottom_edge(bcol_pos, col_pos + 1);
         end
         return median_of_three(left, up, ur);
      end else begin
         if (col_pos != 0) left = tile_at(row_pos, col_pos - 1);
         else left = (bcol_pos == 0) ? tile_at(row_pos - 1, 0) : right_edge(lb, row_pos);
      end
      up = tile_at(row_pos - 1, col_pos);
      ur = lastc ? tile_at(row_pos - 1, col_pos - 1) : tile_at(row_pos - 1, col_pos + 1);
      return median_of_three(left, up, ur);
   endfunction

   function automatic void predict_pixel(logic inv, sample_type x_in, logic fs);
      int               n;
      int               bpr;
      int               x;
      int               p;
      int               res;
      int               stored;
      int               base;
      int               i;
      pixel_result_type want;
      n   = clamp_int(int'(bsize_reg), 2, MAX_N);
      bpr = clamp_int(int'(bpr_reg), 2, MAX_BPR);
      x   = int'(x_in);
      if (fs) begin
         col_pos    = 0;
         row_pos    = 0;
         bcol_pos   = 0;
         top_band   = 1'b1;
         first_tile = 1'b1;
      end
      // saturate a position left beyond a register that shrank
      if (col_pos >= n) col_pos = n - 1;
      if (row_pos >= n) row_pos = n - 1;
      if (bcol_pos >= bpr) bcol_pos = bpr - 1;

      if (mode_reg == MODE_PASS) begin
         res    = x;
         stored = x;
      end else begin
         p = neighbor_prediction(n, bpr);
         if (inv == FUNC_INV) begin
            res = clamp_int(x + p, int'(SAT_LO), int'(SAT_HI));
            stored = res;
         end else begin
            res    = x - p;
            stored = x;
         end
      end
      tile_mem[row_pos * MAX_N + col_pos] = sample_type'(stored);

      want.done = 1'b0;
      col_pos++;
      if (col_pos >= n) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= n) begin
            row_pos   = 0;
            want.done = 1'b1;
            if (inv == FUNC_INV && mode_reg == MODE_DPCM) begin
               base = bcol_pos * EDGE_SPAN;
               for (i = 0; i < n; i++) begin
                  edge_mem[base + i]         = sample_type'(tile_at(i, n - 1));
                  edge_mem[base + MAX_N + i] = sample_type'(tile_at(n - 1, i));
               end
            end
            first_tile = 1'b0;
            bcol_pos++;
            if (bcol_pos >= bpr) begin
               bcol_pos = 0;
               top_band = 1'b0;
            end
         end
      end
      want.value = res[RES_W-1:0];
      expected_pixels.push_back(want);
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         expected_pixels.delete();
         col_pos    = 0;
         row_pos    = 0;
         bcol_pos   = 0;
         top_band   = 1'b1;
         first_tile = 1'b1;
         mode_reg   = MODE_RST;
         bpr_reg    = BPR_RST;
         bsize_reg  = BSIZE_RST;
         mismatches = 0;
         compared   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:  mode_reg  = csr_wdata[0];
               CSR_BPR:   bpr_reg   = csr_wdata[BPR_W-1:0];
               CSR_BSIZE: bsize_reg = csr_wdata[BSIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_pixel(req_func, req_sample_value, req_frame_start);
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("mismatch: result %0d done %0b arrived with no item waiting",
                           rsp_result_value, rsp_block_done);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               compared++;
               if (rsp_result_value !== want.value || rsp_block_done !== want.done) begin
                  if (mismatches < 10)
                     $display({"mismatch at result %0d: value exp %0d got %0d, ",
                               "done exp %0b got %0b"},
                              compared, want.value, rsp_result_value, want.done,
                              rsp_block_done);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_pixels.size();
      checked    <= compared;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the simulation for block_pixel_median_dpcm_top: drives directed and random
// items over several register settings and gives the verdict.
// Depends on bpmd_pkg, bpmd_checker and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bpmd_pkg::*;

   // unmapped register index, writes to it are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic         mode;
      logic [8:0]   bpr;
      logic [4:0]   bsize;
      logic [11:0]  count;
      logic [9:0]   fs_permille;
      logic         restart;
   } phase_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_func         = FUNC_FWD;
   sample_type            req_sample_value = '0;
   logic                  req_frame_start  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   result_type            rsp_result_value;
   logic                  rsp_block_done;

   int fail_count;
   int pending;
   int checked;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int settings_used = 0;

   // stimulus-side copy of the block position and registers
   int   pos_col      = 0;
   int   pos_row      = 0;
   int   pos_bcol     = 0;
   bit   pos_top_band = 1'b1;
   logic cur_mode     = MODE_RST;
   int   cur_bpr      = int'(BPR_RST);
   int   cur_bsize    = int'(BSIZE_RST);

   phase_type phases[8];

   block_pixel_median_dpcm_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_block_done   (rsp_block_done)
   );

   bpmd_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_block_done   (rsp_block_done),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked          (checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // drop valid and hold until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_config(logic mode_v, logic [8:0] bpr_v, logic [4:0] bsize_v);
      logic [8:0] spare;
      logic [8:0] junk;
      spare = 9'($urandom);
      junk  = 9'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= {spare[8:1], mode_v};
      @(posedge clock);
      csr_index <= CSR_BPR;
      csr_wdata <= bpr_v;
      @(posedge clock);
      csr_index <= CSR_BSIZE;
      csr_wdata <= {spare[3:0], bsize_v};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= junk;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_mode  = mode_v;
      cur_bpr   = int'(bpr_v);
      cur_bsize = int'(bsize_v);
      settings_used++;
   endtask

   task automatic push_pixel(logic func_v, sample_type value_v, logic fs_v);
      int   n;
      int   bpr;
      logic f;
      n   = clamp_int(cur_bsize, 2, 16);
      bpr = clamp_int(cur_bpr, 2, 256);
      if (fs_v) begin
         pos_col      = 0;
         pos_row      = 0;
         pos_bcol     = 0;
         pos_top_band = 1'b1;
      end
      if (pos_col >= n) pos_col = n - 1;
      if (pos_row >= n) pos_row = n - 1;
      if (pos_bcol >= bpr) pos_bcol = bpr - 1;
      f = func_v;
      // end every block of the first block row inverse, so its edges are in the
      // store before the next block and the next block row read them
      if (cur_mode == MODE_DPCM && pos_top_band && pos_col == n - 1 && pos_row == n - 1)
         f = FUNC_INV;
      pos_col++;
      if (pos_col >= n) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= n) begin
            pos_row = 0;
            pos_bcol++;
            if (pos_bcol >= bpr) begin
               pos_bcol     = 0;
               pos_top_band = 1'b0;
            end
         end
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_sample_value <= value_v;
      req_frame_start  <= fs_v;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   initial begin
      phase_type  ph;
      int         i;
      int         k;
      logic       fs;
      sample_type v;

      phases[0] = '{MODE_DPCM, 9'd2,   5'd2,  12'd80,   10'd10, 1'b1};
      phases[1] = '{MODE_DPCM, 9'd3,   5'd5,  12'd120,  10'd4,  1'b1};
      // shrink both sizes and carry on inside the frame
      phases[2] = '{MODE_DPCM, 9'd2,   5'd3,  12'd80,   10'd4,  1'b0};
      phases[3] = '{MODE_DPCM, 9'd256, 5'd2,  12'd160,  10'd0,  1'b1};
      phases[4] = '{MODE_DPCM, 9'd2,   5'd20, 12'd200,  10'd0,  1'b1};
      phases[5] = '{MODE_PASS, 9'd4,   5'd3,  12'd60,   10'd25, 1'b1};
      phases[6] = '{MODE_DPCM, 9'd5,   5'd4,  12'd120,  10'd5,  1'b1};
      phases[7] = '{MODE_DPCM, 9'd300, 5'd16, 12'd60,   10'd0,  1'b1};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: two block rows of 2x2 blocks with both registers clamped up,
      // extreme values, a restart inside a block, then passthrough
      set_config(MODE_DPCM, 9'd1, 5'd0);
      for (i = 0; i < 18; i++) begin
         case (i % 4)
            0:       v = SAT_HI;
            1:       v = SAT_LO;
            2:       v = '0;
            default: v = sample_type'($urandom);
         endcase
         push_pixel((i % 3 == 0) ? FUNC_FWD : FUNC_INV, v, (i == 0 || i == 13));
      end
      drain();
      set_config(MODE_PASS, 9'd2, 5'd3);
      push_pixel(FUNC_INV, SAT_LO, 1'b1);
      push_pixel(FUNC_FWD, SAT_HI, 1'b0);
      push_pixel(FUNC_INV, '0, 1'b0);
      push_pixel(FUNC_FWD, sample_type'($urandom), 1'b0);

      for (i = 0; i < 8; i++) begin
         ph = phases[i];
         drain();
         set_config(ph.mode, ph.bpr, ph.bsize);
         for (k = 0; k < ph.count; k++) begin
            if (k % 64 == 0) begin
               case ($urandom_range(3))
                  0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                  1:       begin send_idle_pct = 74; stall_pct = 0;  end
                  2:       begin send_idle_pct = 0;  stall_pct = 74; end
                  default: begin send_idle_pct = 16; stall_pct = 16; end
               endcase
            end
            if (k == ph.count / 2 || $urandom_range(199) == 0) drain();
            fs = (k == 0 && ph.restart) || ($urandom_range(999) < ph.fs_permille);
            case ($urandom_range(7))
               0:       v = SAT_HI;
               1:       v = SAT_LO;
               default: v = sample_type'($urandom);
            endcase
            push_pixel(1'($urandom_range(1)), v, fs);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items over %0d register settings",
               items_sent, settings_used);
      $display("(DPCM, passthrough, clamped sizes), %0d results compared, %0d failures.",
               checked, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation timed out with %0d results outstanding.", pending);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
